// ----- design/disparity_reprojection_3d_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the disparity reprojection block.
// Define ASSERT_OFF to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_REPROJECTION_3D_DEFINES_SVH
`define DISPARITY_REPROJECTION_3D_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define DRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("disparity_reprojection_3d: check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define DRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("disparity_reprojection_3d: check failed");
`else
`define DRP_ASSERT_NOW(lbl, ante, cons)
`define DRP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/drp_pkg.sv -----
// ----------------------------------------------------------------------------
// drp_pkg
// Widths, stage numbering, register indexes, pipeline types and the
// arithmetic of each pipeline stage of the disparity reprojection block.
// ----------------------------------------------------------------------------
package drp_pkg;

  // Field widths of the channels.
  localparam int PIX_W   = 12;
  localparam int DISP_W  = 16;
  localparam int DEPTH_W = 16;
  localparam int PT_W    = 32;
  localparam int FB_W    = 32;
  localparam int COEF_W  = 32;

  // Coordinate bits used and disparity fraction bits.
  localparam int COORD_BITS          = 12;
  localparam int DISPARITY_FRAC_BITS = 4;

  // Divider: positive disparity magnitude, quotient bits for the depth word
  // and for the Q.8 depth.
  localparam int DIV_W = DISP_W - 1;
  localparam int DWB   = FB_W + DISPARITY_FRAC_BITS;
  localparam int QB    = DWB + 8;
  localparam int D8_W  = QB + 1;

  // Matrix row products and sums.
  localparam int MP_W  = COEF_W + COORD_BITS + 1;
  localparam int V_W   = MP_W + 2;
  localparam int MAG_W = V_W - 1;

  // Split of the final product into four partial products.
  localparam int SPLIT  = 24;
  localparam int A1_W   = MAG_W - SPLIT;
  localparam int B1_W   = D8_W - SPLIT;
  localparam int P00_W  = 2 * SPLIT;
  localparam int P01_W  = SPLIT + B1_W;
  localparam int P10_W  = A1_W + SPLIT;
  localparam int P11_W  = A1_W + B1_W;
  localparam int MID_W  = ((P01_W > P10_W) ? P01_W : P10_W) + 1;
  localparam int SUM_W  = MAG_W + D8_W + 1;
  localparam int FRAC_SH = 28;
  localparam int Q_W    = SUM_W - FRAC_SH;

  // Stage numbering.
  localparam int ST_IN   = 0;
  localparam int ST_DIV0 = 1;
  localparam int ST_MUL  = 1;
  localparam int ST_VSUM = 2;
  localparam int ST_VMAG = 3;
  localparam int ST_DW   = ST_DIV0 + DWB;
  localparam int ST_D8   = ST_DIV0 + QB;
  localparam int ST_PP   = ST_D8 + 1;
  localparam int ST_MID  = ST_D8 + 2;
  localparam int ST_SUM  = ST_D8 + 3;
  localparam int ST_OUT  = ST_D8 + 4;
  localparam int NST     = ST_OUT + 1;

  // Configuration register indexes.
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB,
    REG_C00,
    REG_C01,
    REG_C02,
    REG_C10,
    REG_C11,
    REG_C12
  } reg_idx_t;

  // Inverse camera matrix rows, signed Q4.28.
  typedef struct packed {
    logic signed [COEF_W-1:0] c00;
    logic signed [COEF_W-1:0] c01;
    logic signed [COEF_W-1:0] c02;
    logic signed [COEF_W-1:0] c10;
    logic signed [COEF_W-1:0] c11;
    logic signed [COEF_W-1:0] c12;
  } coef_t;

  // One output coordinate lane, X or Y.
  typedef struct packed {
    logic signed [MP_W-1:0] ma;
    logic signed [MP_W-1:0] mb;
    logic signed [V_W-1:0]  v;
    logic                   neg;
    logic [MAG_W-1:0]       mag;
    logic [P00_W-1:0]       p00;
    logic [P01_W-1:0]       p01;
    logic [P10_W-1:0]       p10;
    logic [P11_W-1:0]       p11;
    logic [MID_W-1:0]       mid;
    logic [SUM_W-1:0]       sum;
    logic [PT_W-1:0]        res;
  } lane_t;

  // Contents of one pipeline stage.
  typedef struct packed {
    logic                  dpos;
    logic [DIV_W-1:0]      d;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [DIV_W-1:0]      rem;
    logic [QB-1:0]         quo;
    logic [DEPTH_W-1:0]    dw;
    logic [D8_W-1:0]       d8;
    logic [PT_W-1:0]       z;
    lane_t                 lx;
    lane_t                 ly;
  } pipe_t;

  // Row products of the inverse matrix with column and row.
  function automatic lane_t f_mul(lane_t l, logic signed [COEF_W-1:0] ca,
                                  logic signed [COEF_W-1:0] cb,
                                  logic [COORD_BITS-1:0] col,
                                  logic [COORD_BITS-1:0] row);
    lane_t r;
    r = l;
    r.ma = MP_W'($signed(ca) * $signed({1'b0, col}));
    r.mb = MP_W'($signed(cb) * $signed({1'b0, row}));
    return r;
  endfunction

  // Row sum plus the constant column.
  function automatic lane_t f_vsum(lane_t l, logic signed [COEF_W-1:0] cc);
    lane_t r;
    r = l;
    r.v = V_W'(l.ma) + V_W'(l.mb) + V_W'(cc);
    return r;
  endfunction

  // Sign and magnitude of the row sum.
  function automatic lane_t f_vmag(lane_t l);
    lane_t r;
    r = l;
    r.neg = l.v[V_W-1];
    r.mag = l.v[V_W-1] ? MAG_W'(-l.v) : MAG_W'(l.v);
    return r;
  endfunction

  // One restoring division step: one quotient bit.
  function automatic pipe_t f_div(pipe_t p, logic dbit);
    pipe_t r;
    logic [DIV_W:0] sh;
    logic [DIV_W:0] dd;
    r = p;
    sh = {p.rem, dbit};
    dd = {1'b0, p.d};
    if (sh >= dd) begin
      r.rem = DIV_W'(sh - dd);
      r.quo = {p.quo[QB-2:0], 1'b1};
    end else begin
      r.rem = sh[DIV_W-1:0];
      r.quo = {p.quo[QB-2:0], 1'b0};
    end
    return r;
  endfunction

  // Round to nearest: remainder plus half the divisor reaches the divisor.
  function automatic logic f_rnd(logic [DIV_W-1:0] rem, logic [DIV_W-1:0] d);
    logic [DIV_W:0] acc;
    acc = {1'b0, rem} + {2'b00, d[DIV_W-1:1]};
    return acc >= {1'b0, d};
  endfunction

  // Depth word from the first DWB quotient bits, saturated.
  function automatic pipe_t f_dw(pipe_t p);
    pipe_t r;
    logic [DWB-1:0]     q1;
    logic [DEPTH_W:0]   s;
    r = p;
    q1 = p.quo[DWB-1:0];
    s = {1'b0, q1[DEPTH_W-1:0]} + (DEPTH_W+1)'(f_rnd(p.rem, p.d));
    if (q1 > DWB'({DEPTH_W{1'b1}}) || s[DEPTH_W]) begin
      r.dw = '1;
    end else begin
      r.dw = s[DEPTH_W-1:0];
    end
    return r;
  endfunction

  // Depth in Q.8 and point_z.
  function automatic pipe_t f_d8(pipe_t p);
    pipe_t r;
    logic [D8_W-1:0] d8;
    logic [PT_W-1:0] zmax;
    r = p;
    zmax = {1'b0, {(PT_W-1){1'b1}}};
    d8 = D8_W'(p.quo) + D8_W'(f_rnd(p.rem, p.d));
    r.d8 = d8;
    r.z = (d8 > D8_W'(zmax)) ? zmax : d8[PT_W-1:0];
    return r;
  endfunction

  // Four partial products of magnitude and depth.
  function automatic lane_t f_pp(lane_t l, logic [D8_W-1:0] d8);
    lane_t r;
    r = l;
    r.p00 = P00_W'(l.mag[SPLIT-1:0]) * P00_W'(d8[SPLIT-1:0]);
    r.p01 = P01_W'(l.mag[SPLIT-1:0]) * P01_W'(d8[D8_W-1:SPLIT]);
    r.p10 = P10_W'(l.mag[MAG_W-1:SPLIT]) * P10_W'(d8[SPLIT-1:0]);
    r.p11 = P11_W'(l.mag[MAG_W-1:SPLIT]) * P11_W'(d8[D8_W-1:SPLIT]);
    return r;
  endfunction

  // Middle partial products added.
  function automatic lane_t f_mid(lane_t l);
    lane_t r;
    r = l;
    r.mid = MID_W'(l.p01) + MID_W'(l.p10);
    return r;
  endfunction

  // Full product plus the rounding half of the Q.28 fraction.
  function automatic lane_t f_sum(lane_t l);
    lane_t r;
    r = l;
    r.sum = SUM_W'(l.p00) + (SUM_W'(l.mid) << SPLIT) + (SUM_W'(l.p11) << (2 * SPLIT))
          + (SUM_W'(1) << (FRAC_SH - 1));
    return r;
  endfunction

  // Drop the fraction, saturate and restore the sign.
  function automatic lane_t f_scale(lane_t l);
    lane_t r;
    logic [Q_W-1:0]  q;
    logic [Q_W-1:0]  lim;
    logic [PT_W-1:0] mg;
    r = l;
    q = l.sum[SUM_W-1:FRAC_SH];
    lim = l.neg ? (Q_W'(1) << (PT_W - 1)) : ((Q_W'(1) << (PT_W - 1)) - Q_W'(1));
    mg = (q > lim) ? lim[PT_W-1:0] : q[PT_W-1:0];
    r.res = l.neg ? -mg : mg;
    return r;
  endfunction

endpackage

// ----- design/drp_in_if.sv -----
// ----------------------------------------------------------------------------
// drp_in_if
// Pixel channel: column, row and disparity of one pixel per word.
// ----------------------------------------------------------------------------
interface drp_in_if;
  logic                             valid;
  logic                             ready;
  logic [drp_pkg::PIX_W-1:0]        pixel_column;
  logic [drp_pkg::PIX_W-1:0]        pixel_row;
  logic signed [drp_pkg::DISP_W-1:0] disparity_value;

  modport source (output valid, pixel_column, pixel_row, disparity_value, input ready);
  modport sink   (input valid, pixel_column, pixel_row, disparity_value, output ready);
endinterface

// ----- design/drp_out_if.sv -----
// ----------------------------------------------------------------------------
// drp_out_if
// Point channel: depth word and 3D point of one pixel per word.
// ----------------------------------------------------------------------------
interface drp_out_if;
  logic                              valid;
  logic                              ready;
  logic [drp_pkg::DEPTH_W-1:0]       depth_word;
  logic signed [drp_pkg::PT_W-1:0]   point_x;
  logic signed [drp_pkg::PT_W-1:0]   point_y;
  logic signed [drp_pkg::PT_W-1:0]   point_z;
  logic                              point_valid;

  modport source (output valid, depth_word, point_x, point_y, point_z, point_valid,
                  input ready);
  modport sink   (input valid, depth_word, point_x, point_y, point_z, point_valid,
                  output ready);
endinterface

// ----- design/drp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// drp_cfg_if
// Register write channel: register index and write data per word.
// ----------------------------------------------------------------------------
interface drp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [drp_pkg::CFG_IDX_W-1:0] addr;
  logic [drp_pkg::FB_W-1:0]      wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// ----- design/disparity_reprojection_3d.sv -----
// ----------------------------------------------------------------------------
// disparity_reprojection_3d
// Turns a stream of stereo disparities into depth words and 3D points.
//
// in_bus takes one pixel word (column, row, disparity) per cycle; out_bus
// returns one point word (depth, X, Y, Z, valid flag) per pixel, in order.
// cfg_bus writes the focal-baseline product (index 0) and the two upper
// rows of the inverse camera matrix (indexes 1 to 6); it is always ready,
// and writes beyond index 6 are dropped. Write registers only while no
// pixel is in flight.
// Throughput is one pixel per cycle while out_bus takes every word. The
// depth divider yields one quotient bit per stage over 44 stages; four
// more stages form the scaled product.
// When out_bus stalls, words behind the output register close up into any
// empty stages, and in_bus.ready falls only once every stage holds a word.
// Reset clears the configuration registers and the stage valid bits, which
// empties the pipeline; the stage payload registers are not reset.
`include "disparity_reprojection_3d_defines.svh"

module disparity_reprojection_3d (
  input  logic       clk,
  input  logic       rst_n,
  drp_in_if.sink     in_bus,
  drp_out_if.source  out_bus,
  drp_cfg_if.sink    cfg_bus
);

  localparam int NST = drp_pkg::NST;

  logic [drp_pkg::FB_W-1:0] cfg_r [drp_pkg::NUM_REGS];
  logic [drp_pkg::FB_W-1:0] fb;
  drp_pkg::coef_t           coef;

  drp_pkg::pipe_t stg_r   [NST];
  drp_pkg::pipe_t stg_nxt [NST];
  logic [NST-1:0] vld_r;
  logic [NST-1:0] adv;

  // Configuration registers; writes are always taken.
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < drp_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_bus.valid && cfg_bus.ready && cfg_bus.addr <= drp_pkg::REG_C12) begin
      cfg_r[cfg_bus.addr] <= cfg_bus.wdata;
    end
  end

  assign fb       = cfg_r[drp_pkg::REG_FB];
  assign coef.c00 = cfg_r[drp_pkg::REG_C00];
  assign coef.c01 = cfg_r[drp_pkg::REG_C01];
  assign coef.c02 = cfg_r[drp_pkg::REG_C02];
  assign coef.c10 = cfg_r[drp_pkg::REG_C10];
  assign coef.c11 = cfg_r[drp_pkg::REG_C11];
  assign coef.c12 = cfg_r[drp_pkg::REG_C12];

  // A stage moves on when the output is taken or some stage at or after it
  // is empty.
  always_comb begin
    for (int s = 0; s < NST; s++) begin
      adv[s] = out_bus.ready || (|((~vld_r) >> s));
    end
  end

  assign in_bus.ready = adv[0];

  // Input stage: capture the pixel word.
  always_comb begin
    stg_nxt[0]      = '0;
    stg_nxt[0].col  = in_bus.pixel_column[drp_pkg::COORD_BITS-1:0];
    stg_nxt[0].row  = in_bus.pixel_row[drp_pkg::COORD_BITS-1:0];
    stg_nxt[0].d    = in_bus.disparity_value[drp_pkg::DIV_W-1:0];
    stg_nxt[0].dpos = !in_bus.disparity_value[drp_pkg::DISP_W-1] &&
                      (in_bus.disparity_value != '0);
  end

  // Working stages.
  for (genvar s = 1; s < NST; s++) begin : g_stage
    logic dbit;

    // Dividend bit for this division step: focal product, then zeros.
    if (s - drp_pkg::ST_DIV0 < drp_pkg::FB_W) begin : g_fb_bit
      assign dbit = fb[drp_pkg::FB_W - 1 - (s - drp_pkg::ST_DIV0)];
    end else begin : g_zero_bit
      assign dbit = 1'b0;
    end

    always_comb begin
      stg_nxt[s] = stg_r[s-1];
      if (s == drp_pkg::ST_MUL) begin
        stg_nxt[s].lx = drp_pkg::f_mul(stg_nxt[s].lx, coef.c00, coef.c01,
                                       stg_nxt[s].col, stg_nxt[s].row);
        stg_nxt[s].ly = drp_pkg::f_mul(stg_nxt[s].ly, coef.c10, coef.c11,
                                       stg_nxt[s].col, stg_nxt[s].row);
      end
      if (s == drp_pkg::ST_VSUM) begin
        stg_nxt[s].lx = drp_pkg::f_vsum(stg_nxt[s].lx, coef.c02);
        stg_nxt[s].ly = drp_pkg::f_vsum(stg_nxt[s].ly, coef.c12);
      end
      if (s == drp_pkg::ST_VMAG) begin
        stg_nxt[s].lx = drp_pkg::f_vmag(stg_nxt[s].lx);
        stg_nxt[s].ly = drp_pkg::f_vmag(stg_nxt[s].ly);
      end
      // The depth word is rounded before this stage's division step.
      if (s == drp_pkg::ST_DW) begin
        stg_nxt[s] = drp_pkg::f_dw(stg_nxt[s]);
      end
      if (s >= drp_pkg::ST_DIV0 && s < drp_pkg::ST_DIV0 + drp_pkg::QB) begin
        stg_nxt[s] = drp_pkg::f_div(stg_nxt[s], dbit);
      end
      if (s == drp_pkg::ST_D8) begin
        stg_nxt[s] = drp_pkg::f_d8(stg_nxt[s]);
      end
      if (s == drp_pkg::ST_PP) begin
        stg_nxt[s].lx = drp_pkg::f_pp(stg_nxt[s].lx, stg_nxt[s].d8);
        stg_nxt[s].ly = drp_pkg::f_pp(stg_nxt[s].ly, stg_nxt[s].d8);
      end
      if (s == drp_pkg::ST_MID) begin
        stg_nxt[s].lx = drp_pkg::f_mid(stg_nxt[s].lx);
        stg_nxt[s].ly = drp_pkg::f_mid(stg_nxt[s].ly);
      end
      if (s == drp_pkg::ST_SUM) begin
        stg_nxt[s].lx = drp_pkg::f_sum(stg_nxt[s].lx);
        stg_nxt[s].ly = drp_pkg::f_sum(stg_nxt[s].ly);
      end
      if (s == drp_pkg::ST_OUT) begin
        stg_nxt[s].lx = drp_pkg::f_scale(stg_nxt[s].lx);
        stg_nxt[s].ly = drp_pkg::f_scale(stg_nxt[s].ly);
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    for (int s = 0; s < NST; s++) begin
      if (adv[s]) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  // Stage valid bits travel with the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_bus.valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (adv[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  // Output word; a non-positive disparity gives an all-zero point.
  assign out_bus.valid       = vld_r[NST-1];
  assign out_bus.point_valid = stg_r[NST-1].dpos;
  assign out_bus.depth_word  = stg_r[NST-1].dpos ? stg_r[NST-1].dw : '0;
  assign out_bus.point_x     = stg_r[NST-1].dpos ? stg_r[NST-1].lx.res : '0;
  assign out_bus.point_y     = stg_r[NST-1].dpos ? stg_r[NST-1].ly.res : '0;
  assign out_bus.point_z     = stg_r[NST-1].dpos ? stg_r[NST-1].z : '0;

  // Checks.
  `DRP_ASSERT_NOW(a_invalid_zero, out_bus.valid && !out_bus.point_valid, (out_bus.depth_word == '0) && (out_bus.point_x == '0) && (out_bus.point_y == '0) && (out_bus.point_z == '0))
  `DRP_ASSERT_NOW(a_depth_z_agree, out_bus.valid && (out_bus.depth_word == '0), $unsigned(out_bus.point_z) < 32'd256)
  `DRP_ASSERT_NOW(a_full_when_blocked, !in_bus.ready, out_bus.valid && !out_bus.ready && (&vld_r))
  `DRP_ASSERT_NEXT(a_fb_write, cfg_bus.valid && cfg_bus.ready && (cfg_bus.addr == drp_pkg::REG_FB), fb == $past(cfg_bus.wdata))

endmodule
